### src/sgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_pkg: shared types and constants
// Row sizing, buffer addressing and the controller/datapath command and
// status bundles of the softmax gradient row block.
// ----------------------------------------------------------------------------
package sgr_pkg;

  // Longest row; a row that reaches this length is ended by force.
  localparam int MAX_ROW = 64;
  localparam int ADDR_W  = $clog2(MAX_ROW);
  localparam int CNT_W   = ADDR_W + 1;

  localparam int DATA_W  = 16;
  localparam int ACC_W   = 40;   // exact sum of up to MAX_ROW Q.27 products
  localparam int DIFF_W  = ACC_W + 1;
  localparam int PROD_W  = 33;   // signed 16 x unsigned 16
  localparam int LO_W    = 21;   // low slice of the difference
  localparam int HI_W    = DIFF_W - LO_W;
  localparam int PP_W    = 37;   // partial product width
  localparam int FULL_W  = 58;   // y * difference, Q.42
  localparam int FRAC_SH = 30;   // Q.42 down to Q.12
  localparam int Q_W     = FULL_W - FRAC_SH;

  typedef struct packed {
    logic load;   // transfer of an input element
    logic latch;  // close the row: capture dot and length, clear counters
    logic issue;  // issue one buffer read into the result pipeline
  } sgr_cmd_t;

  typedef struct packed {
    logic row_end;     // element at the input closes the row
    logic prod_busy;   // a product still waits to enter the accumulator
    logic s0_busy;     // a buffer read still needs the row's dot value
    logic adv;         // result pipeline may advance this cycle
    logic issue_last;  // next read is the row's final element
  } sgr_status_t;

endpackage

### src/sgr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_in_if: input element channel
// Valid/ready channel carrying one softmax output, one gradient and the
// row-end mark.
// ----------------------------------------------------------------------------
interface sgr_in_if;
  logic                       valid;
  logic                       ready;
  logic [sgr_pkg::DATA_W-1:0] prob_in;
  logic signed [sgr_pkg::DATA_W-1:0] grad_in;
  logic                       row_last;

  modport source (output valid, output prob_in, output grad_in, output row_last,
                  input ready);
  modport sink (input valid, input prob_in, input grad_in, input row_last,
                output ready);
endinterface

### src/sgr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_out_if: result channel
// Valid/ready channel carrying one gradient result with its row-end mark
// and saturation flag.
// ----------------------------------------------------------------------------
interface sgr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sgr_pkg::DATA_W-1:0] grad_out;
  logic                              out_last;
  logic                              saturated;

  modport source (output valid, output grad_out, output out_last, output saturated,
                  input ready);
  modport sink (input valid, input grad_out, input out_last, input saturated,
                output ready);
endinterface

### src/sgr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module sgr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/sgr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_ctrl: row sequencer
// Loads a row, waits for the dot product to settle, then issues one buffer
// read per cycle while the result pipeline can advance.
// ----------------------------------------------------------------------------
module sgr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sgr_pkg::sgr_status_t status,
  output sgr_pkg::sgr_cmd_t    cmd
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && status.row_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // hold until the last product is summed and the pipeline head is free
        if (!status.prod_busy && !status.s0_busy) begin
          cmd.latch  = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.adv) begin
          cmd.issue = 1'b1;
          if (status.issue_last) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/sgr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_datapath: row buffers, dot accumulator and result pipeline
// Stores each element, sums g*y, and turns buffered elements into rounded,
// saturated y*(g - dot) through a four-stage stallable pipeline.
// ----------------------------------------------------------------------------
module sgr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  sgr_pkg::sgr_cmd_t                 cmd,
  output sgr_pkg::sgr_status_t              status,
  input  logic [sgr_pkg::DATA_W-1:0]        prob_in,
  input  logic signed [sgr_pkg::DATA_W-1:0] grad_in,
  input  logic                              row_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sgr_pkg::DATA_W-1:0] grad_out,
  output logic                              out_last,
  output logic                              saturated
);

  localparam int DW = sgr_pkg::DATA_W;
  localparam int AW = sgr_pkg::ADDR_W;
  localparam int CW = sgr_pkg::CNT_W;

  // counters and row state
  logic [CW-1:0] wr_cnt;
  logic [CW-1:0] row_len;
  logic [AW-1:0] rd_ptr;

  // accumulation
  logic signed [sgr_pkg::PROD_W-1:0] prod;
  logic                              prod_valid;
  logic signed [sgr_pkg::ACC_W-1:0]  acc;
  logic signed [sgr_pkg::ACC_W-1:0]  dot_row;

  // pipeline
  logic                               adv;
  logic [DW-1:0]                      y_rd;
  logic [DW-1:0]                      g_rd;
  logic                               v0, l0;
  logic                               v1, l1;
  logic [DW-1:0]                      y1;
  logic signed [sgr_pkg::DIFF_W-1:0]  diff1;
  logic                               v2, l2;
  logic signed [sgr_pkg::PP_W-1:0]    pp_hi;
  logic [sgr_pkg::PP_W-1:0]           pp_lo;

  logic signed [sgr_pkg::DIFF_W-1:0]  diff_c;
  logic signed [sgr_pkg::PP_W-1:0]    hi_c;
  logic [sgr_pkg::PP_W-1:0]           lo_c;
  logic signed [sgr_pkg::FULL_W-1:0]  full_c;
  logic signed [sgr_pkg::Q_W-1:0]     q_c;
  logic signed [sgr_pkg::PROD_W-1:0]  prod_c;

  assign adv = !out_valid || out_ready;

  assign status.row_end    = row_last || (wr_cnt == CW'(sgr_pkg::MAX_ROW - 1));
  assign status.prod_busy  = prod_valid;
  assign status.s0_busy    = v0;
  assign status.adv        = adv;
  assign status.issue_last = (CW'(rd_ptr) + CW'(1)) == row_len;

  sgr_ram #(.WIDTH(DW), .DEPTH(sgr_pkg::MAX_ROW)) u_prob_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (wr_cnt[AW-1:0]),
    .wdata (prob_in),
    .re    (adv),
    .raddr (rd_ptr),
    .rdata (y_rd)
  );

  sgr_ram #(.WIDTH(DW), .DEPTH(sgr_pkg::MAX_ROW)) u_grad_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (wr_cnt[AW-1:0]),
    .wdata (grad_in),
    .re    (adv),
    .raddr (rd_ptr),
    .rdata (g_rd)
  );

  // g*y, exact
  assign prod_c = $signed({{(sgr_pkg::PROD_W-DW){grad_in[DW-1]}}, grad_in})
                * $signed({{(sgr_pkg::PROD_W-DW){1'b0}}, prob_in});

  // g*2^15 - dot
  assign diff_c = $signed({{(sgr_pkg::DIFF_W-DW-15){g_rd[DW-1]}}, g_rd, 15'b0})
                - $signed({dot_row[sgr_pkg::ACC_W-1], dot_row});

  // y times the two slices of the difference
  assign hi_c = $signed({{(sgr_pkg::PP_W-sgr_pkg::HI_W){diff1[sgr_pkg::DIFF_W-1]}},
                         diff1[sgr_pkg::DIFF_W-1:sgr_pkg::LO_W]})
              * $signed({{(sgr_pkg::PP_W-DW){1'b0}}, y1});
  assign lo_c = {{(sgr_pkg::PP_W-sgr_pkg::LO_W){1'b0}}, diff1[sgr_pkg::LO_W-1:0]}
              * {{(sgr_pkg::PP_W-DW){1'b0}}, y1};

  // recombine, add the rounding half, drop the fraction
  assign full_c = $signed({pp_hi, {sgr_pkg::LO_W{1'b0}}})
                + $signed({{(sgr_pkg::FULL_W-sgr_pkg::PP_W){1'b0}}, pp_lo})
                + $signed(sgr_pkg::FULL_W'(1) <<< (sgr_pkg::FRAC_SH - 1));
  assign q_c = full_c[sgr_pkg::FULL_W-1:sgr_pkg::FRAC_SH];

  // load side
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_cnt     <= '0;
      prod_valid <= 1'b0;
      acc        <= '0;
    end else begin
      prod_valid <= cmd.load;
      if (cmd.load) begin
        wr_cnt <= wr_cnt + CW'(1);
      end
      if (cmd.latch) begin
        wr_cnt <= '0;
        acc    <= '0;
      end else if (prod_valid) begin
        acc <= acc + $signed({{(sgr_pkg::ACC_W-sgr_pkg::PROD_W){prod[sgr_pkg::PROD_W-1]}}, prod});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod <= prod_c;
    end
    if (cmd.latch) begin
      dot_row <= acc;
      row_len <= wr_cnt;
    end
  end

  // result pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.latch) begin
        rd_ptr <= '0;
      end else if (cmd.issue) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (adv) begin
        v0        <= cmd.issue;
        v1        <= v0;
        v2        <= v1;
        out_valid <= v2;
      end
    end
  end

  // result pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      l0    <= status.issue_last;
      l1    <= l0;
      y1    <= y_rd;
      diff1 <= diff_c;
      l2    <= l1;
      pp_hi <= hi_c;
      pp_lo <= lo_c;
      out_last <= l2;
      if (q_c > $signed(sgr_pkg::Q_W'(32767))) begin
        grad_out  <= 16'sh7FFF;
        saturated <= 1'b1;
      end else if (q_c < -$signed(sgr_pkg::Q_W'(32768))) begin
        grad_out  <= 16'sh8000;
        saturated <= 1'b1;
      end else begin
        grad_out  <= q_c[DW-1:0];
        saturated <= 1'b0;
      end
    end
  end

endmodule

### src/softmax_gradient_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_gradient_row: streamed softmax backward pass over one row
// Buffers a row of (y, g) pairs, sums g*y, then emits y*(g - dot) per
// element in input order, rounded to Q4.12 and saturated.
// ----------------------------------------------------------------------------
// Usage:
//   item   : input channel. Each transfer carries prob_in (y, unsigned Q1.15),
//            grad_in (g, signed Q4.12) and row_last. The row closes on
//            row_last or on its 64th element.
//   result : output channel. One transfer per buffered element, in input
//            order; out_last marks the row's final result, saturated marks a
//            clipped value.
// Timing:
//   The row loads one element per cycle. The closing element's product is
//   registered and summed into the accumulator before the dot product is
//   latched. Each result passes the buffer read, difference, partial-product
//   and output registers; results follow one per cycle while the receiver
//   is ready. No new row is taken while the current row's reads are issued:
//   no result can start before the row's dot product is complete, and the
//   sequencer alternates the load and emit phases. The next row is accepted
//   from the cycle after the last buffer read of the current row is issued.
// Reset (rst, synchronous) empties the pipeline and clears the accumulator
// and counters; buffer contents are left as they are.
// When the receiver stalls, the whole result pipeline and buffer read hold.
// ----------------------------------------------------------------------------
module softmax_gradient_row (
  input  logic       clk,
  input  logic       rst,
  sgr_in_if.sink     item,
  sgr_out_if.source  result
);

  sgr_pkg::sgr_cmd_t    cmd;
  sgr_pkg::sgr_status_t status;

  // sequencer: owns the input handshake and the row phases
  sgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // buffers, accumulator and the result pipeline with its output register
  sgr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .prob_in   (item.prob_in),
    .grad_in   (item.grad_in),
    .row_last  (item.row_last),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .grad_out  (result.grad_out),
    .out_last  (result.out_last),
    .saturated (result.saturated)
  );

endmodule
